/* hw/rtl/kclpd_pkg.sv */
// ----------------------------------------------------------------------------
// kclpd_pkg
// Types and constants shared by the key click / long press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package kclpd_pkg;

   localparam int HOLD_W  = 16;
   localparam int GAP_W   = 8;
   localparam int EVT_W   = 8;
   localparam int KEYS_W  = 3;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [HOLD_W-1:0] HOLD_MAX     = 16'hFFFF;
   localparam logic [GAP_W-1:0]  GAP_MAX      = 8'hFF;
   localparam logic [EVT_W-1:0]  CLICK_MAX    = 8'd253;
   localparam logic [EVT_W-1:0]  ST_LONG_HELD = 8'd254;
   localparam logic [EVT_W-1:0]  ST_LONG_REL  = 8'd255;

   localparam logic [KEYS_W-1:0] KEY_DEC = 3'b001;
   localparam logic [KEYS_W-1:0] KEY_SET = 3'b010;
   localparam logic [KEYS_W-1:0] KEY_INC = 3'b100;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_MIN  = 2'd2;

   localparam logic [HOLD_W-1:0] SHORT_MIN_RST = 16'd3;
   localparam logic [GAP_W-1:0]  SHORT_MAX_RST = 8'd50;
   localparam logic [HOLD_W-1:0] LONG_MIN_RST  = 16'd500;

   typedef struct packed {
      logic [KEYS_W-1:0] prev_pressed;
      logic [HOLD_W-1:0] hold_count;
      logic [GAP_W-1:0]  gap_count;
      logic [EVT_W-1:0]  click_count;
      logic [EVT_W-1:0]  status;
      logic [KEYS_W-1:0] last_keys;
   } scan_state_type;

   typedef struct packed {
      logic [HOLD_W-1:0] short_min;
      logic [GAP_W-1:0]  short_max;
      logic [HOLD_W-1:0] long_min;
   } scan_cfg_type;

   typedef struct packed {
      logic [HOLD_W-1:0] hold_ticks;
      logic [KEYS_W-1:0] held_keys;
      logic              event_updated;
      logic [EVT_W-1:0]  key_event;
   } scan_result_type;

endpackage

`default_nettype wire

/* hw/rtl/kclpd_step.sv */
// ----------------------------------------------------------------------------
// kclpd_step
// One scan tick: edge detect, hold/gap counting, click and long press status.
// ----------------------------------------------------------------------------
`default_nettype none

module kclpd_step (
   input  wire logic [kclpd_pkg::KEYS_W-1:0] pins,   // bit0 dec, bit1 set, bit2 inc
   input  wire kclpd_pkg::scan_cfg_type      cfg,
   input  wire kclpd_pkg::scan_state_type    cur,
   output kclpd_pkg::scan_state_type         nxt,
   output kclpd_pkg::scan_result_type        res
);
   import kclpd_pkg::*;

   logic [KEYS_W-1:0] pressed;
   logic [KEYS_W-1:0] rise;
   logic [KEYS_W-1:0] fall;
   logic [HOLD_W-1:0] hold0;
   logic [HOLD_W-1:0] short_max_ext;
   logic              wrote;

   assign pressed       = (~pins) & (KEY_DEC | KEY_SET | KEY_INC);
   assign rise          = pressed & ~cur.prev_pressed;
   assign fall          = cur.prev_pressed & ~pressed;
   assign hold0         = (rise != '0) ? '0 : cur.hold_count;
   assign short_max_ext = {{(HOLD_W-GAP_W){1'b0}}, cfg.short_max};

   always_comb begin
      nxt              = cur;
      wrote            = 1'b0;
      nxt.prev_pressed = pressed;
      nxt.hold_count   = hold0;

      if (pressed != '0) begin
         nxt.last_keys = pressed;
         if (hold0 > cfg.long_min) begin
            nxt.status = ST_LONG_HELD;
            wrote      = 1'b1;
         end
         if (hold0 != HOLD_MAX) begin
            nxt.hold_count = hold0 + 1'b1;
         end
      end

      // classify the hold that just ended
      if (fall != '0) begin
         if (nxt.hold_count > cfg.short_min && nxt.hold_count <= short_max_ext) begin
            if (cur.click_count < CLICK_MAX) begin
               nxt.click_count = cur.click_count + 1'b1;
            end
         end else if (nxt.hold_count > short_max_ext && nxt.hold_count <= cfg.long_min) begin
            nxt.click_count = '0;
         end else if (nxt.hold_count > cfg.long_min) begin
            nxt.status = ST_LONG_REL;
            wrote      = 1'b1;
         end
         nxt.gap_count = '0;
      end

      // gap long enough: flush pending clicks to status
      if (nxt.gap_count > cfg.short_max && nxt.click_count != '0) begin
         nxt.status      = nxt.click_count;
         nxt.click_count = '0;
         wrote           = 1'b1;
      end
      if (nxt.gap_count != GAP_MAX) begin
         nxt.gap_count = nxt.gap_count + 1'b1;
      end
   end

   assign res.key_event     = nxt.status;
   assign res.event_updated = wrote;
   assign res.held_keys     = nxt.last_keys;
   assign res.hold_ticks    = nxt.hold_count;

endmodule

`default_nettype wire

/* hw/rtl/key_click_long_press_detector_top.sv */
// The result passes through the input register and then the result register.
// Throughput: one item per clock while the output side is not stalled; the scan state
// updates once per item as it leaves the input register, set by the single-tick step logic.
// Reset (synchronous, active high) clears all counters, status and key state,
// empties both registers and loads the default thresholds 3, 50 and 500.
// ----------------------------------------------------------------------------
// key_click_long_press_detector_top
// Multi-click / long press key scanner, one scan tick per stream item.
// ----------------------------------------------------------------------------
`default_nettype none

module key_click_long_press_detector_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] dec_pin, [1] set_pin, [2] inc_pin
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] key_event, [8] event_updated,
                                         // [11:9] held_keys, [27:12] hold_ticks
   input  wire logic                                csr_we,
   input  wire logic [kclpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [kclpd_pkg::CSR_W-1:0]         csr_wdata
);
   import kclpd_pkg::*;

   localparam int RES_W = $bits(scan_result_type);

   scan_cfg_type      cfg_ff;
   scan_state_type    state_ff;
   scan_state_type    state_in;
   scan_result_type   res_in;
   scan_result_type   res_ff;
   logic [KEYS_W-1:0] pins_ff;
   logic              in_vld_ff;
   logic              out_vld_ff;
   logic              out_free;
   logic              advance;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_min <= SHORT_MIN_RST;
         cfg_ff.short_max <= SHORT_MAX_RST;
         cfg_ff.long_min  <= LONG_MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHORT_MIN: cfg_ff.short_min <= csr_wdata;
            CSR_SHORT_MAX: cfg_ff.short_max <= csr_wdata[GAP_W-1:0];
            CSR_LONG_MIN:  cfg_ff.long_min  <= csr_wdata;
            default: ;
         endcase
      end
   end

   kclpd_step u_step (
      .pins (pins_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (out_free) begin
            out_vld_ff <= in_vld_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pins_ff <= req_tdata[KEYS_W-1:0];
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(32-RES_W){1'b0}}, res_ff};

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the key click / long press detector. Scan ticks stream in as
// active-low pin levels. A local scanner model predicts every result item, and
// each result is checked field by field. Threshold settings change between
// phases while the block is idle. Both stream sides idle at random, and there
// is one long receiver hold-off and one saturation run.
// ----------------------------------------------------------------------------

module tb;

   import kclpd_pkg::*;

   localparam int RESET_CYCLES   = 12;
   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int HOLD_CAP       = 520;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;     // [0] dec_pin, [1] set_pin, [2] inc_pin
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;          // [7:0] key_event, [8] event_updated,
                                              // [11:9] held_keys, [27:12] hold_ticks
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // scanner model state and thresholds
   logic [KEYS_W-1:0]     sc_prev = '0;
   logic [HOLD_W-1:0]     sc_hold = '0;
   logic [GAP_W-1:0]      sc_gap = '0;
   logic [EVT_W-1:0]      sc_clicks = '0;
   logic [EVT_W-1:0]      sc_status = '0;
   logic [KEYS_W-1:0]     sc_keys = '0;
   logic [HOLD_W-1:0]     thr_short_min = SHORT_MIN_RST;
   logic [GAP_W-1:0]      thr_short_max = SHORT_MAX_RST;
   logic [HOLD_W-1:0]     thr_long_min = LONG_MIN_RST;

   logic [2:0]            pending_pins[$];
   scan_result_type       expected_reports[$];
   int                    items_pushed = 0;
   int                    req_gap_max = 16;
   int                    rsp_gap_max = 16;
   int                    holdoffs_asked = 0;
   int                    holdoffs_granted = 0;
   int                    fail_count = 0;
   int                    req_wait = 0;
   int                    rsp_wait = 0;
   int                    holdoff_left = 0;

   key_click_long_press_detector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // one scan tick of the key scanner
   function automatic scan_result_type scan_tick(input logic [2:0] pins);
      logic [KEYS_W-1:0] pressed;
      logic [KEYS_W-1:0] rise;
      logic [KEYS_W-1:0] fall;
      scan_result_type   res;
      pressed = ~pins;
      rise = pressed & ~sc_prev;
      fall = sc_prev & ~pressed;
      sc_prev = pressed;
      res.event_updated = 1'b0;
      if (rise != '0) sc_hold = '0;
      if (pressed != '0) begin
         sc_keys = pressed;
         if (sc_hold > thr_long_min) begin
            sc_status = ST_LONG_HELD;
            res.event_updated = 1'b1;
         end
         if (sc_hold != HOLD_MAX) sc_hold = sc_hold + 1'b1;
      end
      if (fall != '0) begin
         if (sc_hold > thr_short_min && sc_hold <= thr_short_max) begin
            if (sc_clicks < CLICK_MAX) sc_clicks = sc_clicks + 1'b1;
         end else if (sc_hold > thr_short_max && sc_hold <= thr_long_min) begin
            sc_clicks = '0;
         end else if (sc_hold > thr_long_min) begin
            sc_status = ST_LONG_REL;
            res.event_updated = 1'b1;
         end
         sc_gap = '0;
      end
      // a quiet gap longer than the click window flushes pending clicks
      if (sc_gap > thr_short_max && sc_clicks != '0) begin
         sc_status = sc_clicks;
         sc_clicks = '0;
         res.event_updated = 1'b1;
      end
      if (sc_gap != GAP_MAX) sc_gap = sc_gap + 1'b1;
      res.key_event = sc_status;
      res.held_keys = sc_keys;
      res.hold_ticks = sc_hold;
      return res;
   endfunction

   function automatic void add_keys(input logic [2:0] pressed, input int ticks);
      for (int i = 0; i < ticks; i++) pending_pins.push_back(~pressed);
      items_pushed += ticks;
   endfunction

   function automatic int capped(input int v);
      return (v > HOLD_CAP) ? HOLD_CAP : v;
   endfunction

   // random key gestures scaled to the current thresholds
   function automatic void add_gestures(input int n_items);
      int         smin;
      int         smax;
      int         lmin;
      int         goal;
      int         reps;
      logic [2:0] keys;
      logic [2:0] other;
      smin = int'(thr_short_min);
      smax = int'(thr_short_max);
      lmin = int'(thr_long_min);
      goal = items_pushed + n_items;
      while (items_pushed < goal) begin
         keys = 3'($urandom_range(1, 7));
         other = 3'($urandom_range(1, 7));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               add_keys(keys, $urandom_range(capped(smin + 1), capped(smax + 1)));
               add_keys('0, $urandom_range(1, capped(smax)));
            end
            3: add_keys(keys, $urandom_range(capped(smax + 1), capped(lmin + 1)));
            4: add_keys(keys, $urandom_range(capped(lmin), capped(lmin + 3)));
            5: add_keys('0, $urandom_range(capped(smax), capped(smax + 3)));
            6: begin
               reps = $urandom_range(2, 6);
               for (int i = 0; i < reps; i++)
                  add_keys(3'($urandom_range(0, 7)), $urandom_range(1, 3));
            end
            7: begin
               // rolling press: second key joins, first key leaves
               add_keys(keys, $urandom_range(1, 4));
               add_keys(keys | other, $urandom_range(1, 4));
               add_keys(other, $urandom_range(1, 4));
            end
            8: add_keys(keys, $urandom_range(1, (smin > 8) ? 8 : smin));
            default: add_keys(3'($urandom_range(0, 7)), 1);
         endcase
      end
   endfunction

   task automatic set_thresholds(input logic [HOLD_W-1:0] smin, input logic [GAP_W-1:0] smax,
                                 input logic [HOLD_W-1:0] lmin);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SHORT_MIN;
      csr_wdata <= smin;
      @(posedge clock);
      csr_index <= CSR_SHORT_MAX;
      csr_wdata <= {{(CSR_W-GAP_W){1'b0}}, smax};
      @(posedge clock);
      csr_index <= CSR_LONG_MIN;
      csr_wdata <= lmin;
      @(posedge clock);
      csr_we <= 1'b0;
      thr_short_min = smin;
      thr_short_max = smax;
      thr_long_min = lmin;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_pins.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic report_field(input string name, input int want, input int got);
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_reports.push_back(scan_tick(req_tdata[2:0]));
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_pins.size() != 0) begin
               req_tdata <= {5'b0, pending_pins.pop_front()};
               req_tvalid <= 1'b1;
               req_wait = $urandom_range(0, req_gap_max);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      scan_result_type got;
      scan_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
         holdoff_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = scan_result_type'(rsp_tdata[27:0]);
            if (expected_reports.size() == 0) begin
               $display("%0t: result %h arrived with none expected", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               if (got.key_event !== want.key_event)
                  report_field("key_event", int'(want.key_event), int'(got.key_event));
               if (got.event_updated !== want.event_updated)
                  report_field("event_updated", int'(want.event_updated),
                               int'(got.event_updated));
               if (got.held_keys !== want.held_keys)
                  report_field("held_keys", int'(want.held_keys), int'(got.held_keys));
               if (got.hold_ticks !== want.hold_ticks)
                  report_field("hold_ticks", int'(want.hold_ticks), int'(got.hold_ticks));
               if (rsp_tdata[31:28] !== 4'b0)
                  report_field("tdata padding", 0, int'(rsp_tdata[31:28]));
            end
            rsp_wait = $urandom_range(0, rsp_gap_max);
         end
         if (holdoffs_granted != holdoffs_asked) begin
            holdoffs_granted++;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[key_click_long_press_detector_top] ERROR");
      $finish;
   end

   initial begin : stimulus
      int smin_r;
      int smax_r;
      int lmin_r;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: clicks, flush, long hold and release, overlaps, medium hold
      set_thresholds(16'd1, 8'd3, 16'd4);
      add_keys(KEY_SET, 2);
      add_keys('0, 1);
      add_keys(KEY_INC, 3);
      add_keys('0, 4);
      add_keys(KEY_DEC | KEY_SET | KEY_INC, 6);
      add_keys('0, 1);
      add_keys(KEY_DEC, 1);
      add_keys(KEY_DEC | KEY_SET, 1);
      add_keys(KEY_SET, 1);
      add_keys(KEY_INC, 1);   // press and release on different keys in one tick
      add_keys('0, 1);
      add_keys(KEY_DEC, 4);
      add_keys('0, 1);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         smin_r = $urandom_range(0, 4);
         smax_r = $urandom_range(smin_r, smin_r + 12);
         lmin_r = $urandom_range(smax_r + 1, smax_r + 40);
         case (phase)
            0: set_thresholds(SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST);
            1: set_thresholds(16'd0, 8'd0, 16'd0);
            3: set_thresholds(16'hFFFF, 8'd254, 16'd65534);
            5: set_thresholds(16'hFFFF, 8'd0, 16'd0);
            7: set_thresholds(16'd0, 8'd254, 16'd65534);
            default: set_thresholds(16'(smin_r), 8'(smax_r), 16'(lmin_r));
         endcase
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         if (phase == 2) begin
            // receiver stalls long while the sender keeps the input full
            req_gap_max = 0;
            holdoffs_asked++;
         end
         add_gestures(PHASE_ITEMS);
         wait_drained();
      end

      // saturation: click count and gap count hit their ceilings
      set_thresholds(16'd0, 8'd254, 16'd65534);
      req_gap_max = 0;
      rsp_gap_max = 0;
      for (int i = 0; i < 260; i++) begin
         add_keys(KEY_DEC, 1);
         add_keys('0, 1);
      end
      add_keys('0, 260);
      add_keys(KEY_DEC | KEY_SET | KEY_INC, 6);
      add_keys('0, 2);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[key_click_long_press_detector_top] OK");
      end else begin
         $display("[key_click_long_press_detector_top] ERROR");
      end
      $finish;
   end

endmodule

/* key_click_long_press_detector_top.f */
hw/rtl/kclpd_pkg.sv
hw/rtl/kclpd_step.sv
hw/rtl/key_click_long_press_detector_top.sv
verif/tb.sv
